// ===== design/rtct_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtct_pkg
// Shared types, codes and sizing helpers of the ready trigger completion table.
// -----------------------------------------------------------------------------
package rtct_pkg;

   localparam int SLOTS_DEFAULT       = 8192;
   localparam int HANDLE_BITS_DEFAULT = 32;
   localparam int ONGOING_BITS        = 14;
   localparam int QUEUE_DEPTH         = 2;

   typedef logic [2:0] op_type;
   localparam op_type OP_ENQ   = 3'd0;
   localparam op_type OP_SET   = 3'd1;
   localparam op_type OP_DEQ   = 3'd2;
   localparam op_type OP_DONE  = 3'd3;
   localparam op_type OP_RESET = 3'd4;

   typedef logic [1:0] err_type;
   localparam err_type ERR_NONE         = 2'd0;
   localparam err_type ERR_FULL         = 2'd1;
   localparam err_type ERR_NONE_ONGOING = 2'd2;
   localparam err_type ERR_UNALLOC      = 2'd3;

   typedef struct packed {
      logic enq;
      logic set_rdy;
      logic deq;
      logic done;
      logic clr;
   } cls_type;

   localparam int CLS_BITS = $bits(cls_type);

   // Slots per flag word; keeps at least two words in the table when there are eight slots or more.
   function automatic int word_bits(input int slots);
      return (slots >= 64) ? 32 : 4;
   endfunction

endpackage

// ===== design/rtct_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtct_front
// Request intake: takes a beat, decodes the operation and hands it to the queue.
// -----------------------------------------------------------------------------
module rtct_front #(
   parameter int SLOTS       = rtct_pkg::SLOTS_DEFAULT,
   parameter int HANDLE_BITS = rtct_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rtct_pkg::op_type         req_op,
   input  logic [HANDLE_BITS-1:0]   req_handle,
   input  logic                     req_initial_ready,
   input  logic [$clog2(SLOTS)-1:0] req_slot,
   output logic                     push,
   input  logic                     push_full,
   output rtct_pkg::cls_type        push_cls,
   output logic [HANDLE_BITS-1:0]   push_handle,
   output logic                     push_ready,
   output logic [$clog2(SLOTS)-1:0] push_slot
);

   localparam int SB = $clog2(SLOTS);

   logic                    valid_ff;
   logic                    valid_in;
   rtct_pkg::cls_type       cls_ff;
   rtct_pkg::cls_type       cls_in;
   logic [HANDLE_BITS-1:0]  handle_ff;
   logic                    rdy_ff;
   logic [SB-1:0]           slot_ff;
   logic                    take;

   assign req_stall = valid_ff && push_full;
   assign take      = req_valid && !req_stall;
   assign push      = valid_ff && !push_full;

   always_comb begin
      cls_in = '0;
      case (req_op)
         rtct_pkg::OP_ENQ:   cls_in.enq     = 1'b1;
         rtct_pkg::OP_SET:   cls_in.set_rdy = 1'b1;
         rtct_pkg::OP_DEQ:   cls_in.deq     = 1'b1;
         rtct_pkg::OP_DONE:  cls_in.done    = 1'b1;
         rtct_pkg::OP_RESET: cls_in.clr     = 1'b1;
         default:            cls_in         = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cls_ff    <= cls_in;
         handle_ff <= req_handle;
         rdy_ff    <= req_initial_ready;
         slot_ff   <= req_slot;
      end
   end

   assign push_cls    = cls_ff;
   assign push_handle = handle_ff;
   assign push_ready  = rdy_ff;
   assign push_slot   = slot_ff;

endmodule

// ===== design/rtct_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtct_queue
// Short command queue between the decode front and the table engine.
// -----------------------------------------------------------------------------
module rtct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int DEPTH = rtct_pkg::QUEUE_DEPTH;
   localparam int PB    = $clog2(DEPTH);
   localparam int NB    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff;
   logic [PB-1:0]    wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff;
   logic [PB-1:0]    rd_ptr_in;
   logic [NB-1:0]    count_ff;
   logic [NB-1:0]    count_in;

   assign full      = (count_ff == NB'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/rtct_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtct_back
// Table engine: handle store, ready/pending flag words, counters and the
// word-per-cycle dequeue scan, with the response register.
// -----------------------------------------------------------------------------
module rtct_back #(
   parameter int SLOTS       = rtct_pkg::SLOTS_DEFAULT,
   parameter int HANDLE_BITS = rtct_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  rtct_pkg::cls_type        q_cls,
   input  logic [HANDLE_BITS-1:0]   q_handle,
   input  logic                     q_ready,
   input  logic [$clog2(SLOTS)-1:0] q_slot,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [HANDLE_BITS-1:0]   rsp_handle_out,
   output logic [$clog2(SLOTS)-1:0] rsp_slot_index,
   output rtct_pkg::err_type        rsp_error
);

   localparam int SB    = $clog2(SLOTS);
   localparam int CB    = $clog2(SLOTS + 1);
   localparam int WB    = rtct_pkg::word_bits(SLOTS);
   localparam int LW    = $clog2(WB);
   localparam int WAB   = SB - LW;
   localparam int DEPTH = 1 << WAB;
   localparam int EW    = CB - LW;
   localparam int OB    = rtct_pkg::ONGOING_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WRITE  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_HANDLE = 2'd3;

   logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
   logic [2*WB-1:0]        flag_mem   [DEPTH];

   logic [1:0]             state_ff,    state_in;
   logic [CB-1:0]          count_ff,    count_in;
   logic [OB-1:0]          ongoing_ff,  ongoing_in;
   logic [CB-1:0]          cursor_ff,   cursor_in;
   logic [WAB-1:0]         addr_ff,     addr_in;
   logic                   first_ff,    first_in;
   logic [LW-1:0]          bit_ff,      bit_in;
   logic                   wr_enq_ff,   wr_enq_in;
   logic                   wr_rdy_ff,   wr_rdy_in;
   logic [SB-1:0]          hit_idx_ff,  hit_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SB-1:0]          rsp_idx_ff,  rsp_idx_in;
   rtct_pkg::err_type      rsp_err_ff,  rsp_err_in;
   logic                   rsp_load;

   logic                   h_we, h_re;
   logic [SB-1:0]          h_waddr, h_raddr;
   logic [HANDLE_BITS-1:0] h_wdata;
   logic [HANDLE_BITS-1:0] handle_rdata_ff;
   logic                   f_we, f_re;
   logic [WAB-1:0]         f_waddr, f_raddr;
   logic [2*WB-1:0]        f_wdata;
   logic [2*WB-1:0]        flag_rdata_ff;

   logic                   out_free;
   logic [WB-1:0]          pend_r, rdy_r, pend_w, rdy_w;
   logic [WB-1:0]          hit_vec;
   logic                   any_hit;
   logic [LW-1:0]          sel_bit;
   logic [EW-1:0]          end_word;
   logic [CB-1:0]          count_m1;
   logic [WAB-1:0]         last_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_r    = flag_rdata_ff[2*WB-1:WB];
   assign rdy_r     = flag_rdata_ff[WB-1:0];
   assign end_word  = count_ff[CB-1:LW];
   assign count_m1  = count_ff - CB'(1);
   assign last_word = count_m1[SB-1:LW];

   always_comb begin
      for (int b = 0; b < WB; b++) begin
         hit_vec[b] = pend_r[b] && rdy_r[b]
                      && (!first_ff || (LW'(b) >= cursor_ff[LW-1:0]))
                      && ((EW'(addr_ff) < end_word) || (LW'(b) < count_ff[LW-1:0]));
      end
   end

   always_comb begin
      sel_bit = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (hit_vec[b]) begin
            sel_bit = LW'(b);
         end
      end
   end

   assign any_hit = |hit_vec;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ongoing_in    = ongoing_ff;
      cursor_in     = cursor_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      bit_in        = bit_ff;
      wr_enq_in     = wr_enq_ff;
      wr_rdy_in     = wr_rdy_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_handle_in = '0;
      rsp_idx_in    = '0;
      rsp_err_in    = rtct_pkg::ERR_NONE;
      q_pop         = 1'b0;
      h_we          = 1'b0;
      h_waddr       = count_ff[SB-1:0];
      h_wdata       = q_handle;
      h_re          = 1'b0;
      h_raddr       = {addr_ff, sel_bit};
      f_we          = 1'b0;
      f_waddr       = addr_ff;
      f_re          = 1'b0;
      f_raddr       = addr_ff;
      pend_w        = pend_r;
      rdy_w         = rdy_r;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop    = 1'b1;
               rsp_load = 1'b1;
               if (q_cls.enq) begin
                  if (count_ff == CB'(SLOTS)) begin
                     rsp_err_in = rtct_pkg::ERR_FULL;
                  end else begin
                     h_we       = 1'b1;
                     f_re       = 1'b1;
                     f_raddr    = count_ff[SB-1:LW];
                     addr_in    = count_ff[SB-1:LW];
                     bit_in     = count_ff[LW-1:0];
                     wr_enq_in  = 1'b1;
                     wr_rdy_in  = q_ready;
                     rsp_idx_in = count_ff[SB-1:0];
                     count_in   = count_ff + CB'(1);
                     if (ongoing_ff != '1) begin
                        ongoing_in = ongoing_ff + OB'(1);
                     end
                     state_in   = ST_WRITE;
                  end
               end else if (q_cls.set_rdy) begin
                  if (CB'(q_slot) >= count_ff) begin
                     rsp_err_in = rtct_pkg::ERR_UNALLOC;
                  end else begin
                     f_re      = 1'b1;
                     f_raddr   = q_slot[SB-1:LW];
                     addr_in   = q_slot[SB-1:LW];
                     bit_in    = q_slot[LW-1:0];
                     wr_enq_in = 1'b0;
                     state_in  = ST_WRITE;
                  end
               end else if (q_cls.deq) begin
                  if ((ongoing_ff == '0) || (cursor_ff >= count_ff)) begin
                     cursor_in = '0;
                  end else begin
                     rsp_load = 1'b0;
                     f_re     = 1'b1;
                     f_raddr  = cursor_ff[SB-1:LW];
                     addr_in  = cursor_ff[SB-1:LW];
                     first_in = 1'b1;
                     state_in = ST_SCAN;
                  end
               end else if (q_cls.done) begin
                  if (ongoing_ff == '0) begin
                     rsp_err_in = rtct_pkg::ERR_NONE_ONGOING;
                  end else begin
                     ongoing_in = ongoing_ff - OB'(1);
                  end
               end else if (q_cls.clr) begin
                  count_in = '0;
               end
            end
         end
         ST_WRITE: begin
            f_we = 1'b1;
            if (wr_enq_ff) begin
               pend_w[bit_ff] = 1'b1;
               rdy_w[bit_ff]  = wr_rdy_ff;
            end else begin
               rdy_w[bit_ff]  = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (any_hit) begin
               f_we            = 1'b1;
               pend_w[sel_bit] = 1'b0;
               rdy_w[sel_bit]  = 1'b0;
               h_re            = 1'b1;
               hit_idx_in      = {addr_ff, sel_bit};
               cursor_in       = CB'({addr_ff, sel_bit}) + CB'(1);
               state_in        = ST_HANDLE;
            end else if (addr_ff == last_word) begin
               if (out_free) begin
                  rsp_load  = 1'b1;
                  cursor_in = '0;
                  state_in  = ST_IDLE;
               end
            end else begin
               addr_in  = addr_ff + WAB'(1);
               f_re     = 1'b1;
               f_raddr  = addr_ff + WAB'(1);
               first_in = 1'b0;
            end
         end
         ST_HANDLE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_handle_in = handle_rdata_ff;
               rsp_idx_in    = hit_idx_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      f_wdata = {pend_w, rdy_w};
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ongoing_ff   <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ongoing_ff   <= ongoing_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      first_ff   <= first_in;
      bit_ff     <= bit_in;
      wr_enq_ff  <= wr_enq_in;
      wr_rdy_ff  <= wr_rdy_in;
      hit_idx_ff <= hit_idx_in;
      if (rsp_load) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         handle_mem[h_waddr] <= h_wdata;
      end
      if (h_re) begin
         handle_rdata_ff <= handle_mem[h_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         flag_mem[f_waddr] <= f_wdata;
      end
      if (f_re) begin
         flag_rdata_ff <= flag_mem[f_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_slot_index = rsp_idx_ff;
   assign rsp_error      = rsp_err_ff;

endmodule

// ===== design/ready_trigger_completion_table.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ready_trigger_completion_table
// Completion table with in-order slot allocation and a ready/pending scan.
// -----------------------------------------------------------------------------
// Every request beat gives exactly one response beat, in order. A decode front
// and a two-entry command queue take new beats while the table engine works.
// The engine keeps handles in one memory and ready/pending flags packed into
// words of one memory, so each flag update is a read-modify-write: an enqueue or
// set_ready that writes reads the word from idle and writes it back in the write
// state; done, reset, unknown codes and the full and unallocated error cases
// answer from idle. A dequeue with nothing ongoing or with its cursor at or past
// slot_count answers from idle; else it scans the flag words in turn from the
// cursor's word to the last allocated one and enters the handle state when it
// finds a slot (32 slots per word if SLOTS >= 64, else 4). The scan of that
// single-ported flag memory sets the worst case, and response stalls add to it.
// No clearing pass follows reset: the allocating enqueue rewrites a slot's flags.
// -----------------------------------------------------------------------------
module ready_trigger_completion_table #(
   parameter int SLOTS       = rtct_pkg::SLOTS_DEFAULT,
   parameter int HANDLE_BITS = rtct_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_op,
   input  logic [HANDLE_BITS-1:0]   req_handle,
   input  logic                     req_initial_ready,
   input  logic [$clog2(SLOTS)-1:0] req_slot,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [HANDLE_BITS-1:0]   rsp_handle_out,
   output logic [$clog2(SLOTS)-1:0] rsp_slot_index,
   output logic [1:0]               rsp_error
);

   localparam int SB = $clog2(SLOTS);
   localparam int QW = rtct_pkg::CLS_BITS + 1 + SB + HANDLE_BITS;

   logic                   push;
   logic                   push_full;
   rtct_pkg::cls_type      push_cls;
   logic [HANDLE_BITS-1:0] push_handle;
   logic                   push_ready;
   logic [SB-1:0]          push_slot;
   logic                   q_pop;
   logic                   q_valid;
   logic [QW-1:0]          q_data;
   rtct_pkg::err_type      rsp_err;

   rtct_front #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (rtct_pkg::op_type'(req_op)),
      .req_handle        (req_handle),
      .req_initial_ready (req_initial_ready),
      .req_slot          (req_slot),
      .push              (push),
      .push_full         (push_full),
      .push_cls          (push_cls),
      .push_handle       (push_handle),
      .push_ready        (push_ready),
      .push_slot         (push_slot)
   );

   rtct_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cls, push_ready, push_slot, push_handle}),
      .full      (push_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   rtct_back #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cls          (rtct_pkg::cls_type'(q_data[QW-1:QW-rtct_pkg::CLS_BITS])),
      .q_handle       (q_data[HANDLE_BITS-1:0]),
      .q_ready        (q_data[SB+HANDLE_BITS]),
      .q_slot         (q_data[SB+HANDLE_BITS-1:HANDLE_BITS]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot_index (rsp_slot_index),
      .rsp_error      (rsp_err)
   );

   assign rsp_error = rsp_err;

endmodule

// ===== design/rtct_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtct_checker
// Port-level checks of the completion table, bound to the top level.
// -----------------------------------------------------------------------------
module rtct_checker #(
   parameter int SLOTS       = rtct_pkg::SLOTS_DEFAULT,
   parameter int HANDLE_BITS = rtct_pkg::HANDLE_BITS_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [2:0]               req_op,
   input logic [HANDLE_BITS-1:0]   req_handle,
   input logic                     req_initial_ready,
   input logic [$clog2(SLOTS)-1:0] req_slot,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_found,
   input logic [HANDLE_BITS-1:0]   rsp_handle_out,
   input logic [$clog2(SLOTS)-1:0] rsp_slot_index,
   input logic [1:0]               rsp_error
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_handle_out) && $stable(rsp_slot_index) && $stable(rsp_error))
      else $error("stalled response beat changed");

   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_error == rtct_pkg::ERR_NONE)
      else $error("found beat carries an error");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_handle_out == '0)
      else $error("handle set on a beat without a found slot");

   a_error_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != rtct_pkg::ERR_NONE |-> rsp_slot_index == '0 && !rsp_found)
      else $error("error beat carries a slot index");

endmodule

bind ready_trigger_completion_table rtct_checker #(
   .SLOTS       (SLOTS),
   .HANDLE_BITS (HANDLE_BITS)
) u_checker (.*);
